/* rtl/gyi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gyi_pkg: shared types and constants of the gyro yaw integrator
// Payload types, status codes and register indexes used by the channel
// interfaces and the integrator unit.
// ----------------------------------------------------------------------------
package gyi_pkg;

	// Default number of calibration samples averaged into the bias.
	localparam int CAL_SAMPLES_DEF = 500;

	localparam int RAW_W      = 16;
	localparam int TIME_W     = 32;
	localparam int YAW_W      = 64;
	localparam int DEADBAND_W = 24;
	localparam int INTERVAL_W = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = INTERVAL_W'(4);

	typedef logic signed [RAW_W-1:0]  raw_t;
	typedef logic [TIME_W-1:0]        time_t;
	typedef logic signed [YAW_W-1:0]  yaw_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

	typedef enum logic [2:0] {
		ST_FIRST    = 3'd0,  // first update, time recorded only
		ST_SKIP     = 3'd1,  // update too soon, skipped
		ST_INTEG    = 3'd2,  // update integrated
		ST_CAL      = 3'd3,  // calibration sample summed
		ST_CAL_DONE = 3'd4   // calibration sample summed, bias latched
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADBAND     = 2'd0,
		REG_MIN_INTERVAL = 2'd1
	} reg_idx_t;

endpackage

`default_nettype wire

/* rtl/gyi_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gyi_if: channel interfaces of the gyro yaw integrator
// Sample request, result request and register write channels, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface gyi_sample_if;
	import gyi_pkg::*;
	logic  valid;
	logic  ready;
	logic  func;
	time_t now_ms;
	raw_t  gyro_raw;
	modport source (output valid, func, now_ms, gyro_raw, input ready);
	modport sink   (input valid, func, now_ms, gyro_raw, output ready);
endinterface

interface gyi_result_if;
	import gyi_pkg::*;
	logic    valid;
	logic    ready;
	yaw_t    yaw_acc;
	status_t status;
	modport source (output valid, yaw_acc, status, input ready);
	modport sink   (input valid, yaw_acc, status, output ready);
endinterface

interface gyi_cfg_if;
	import gyi_pkg::*;
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/gyro_yaw_integrator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gyro_yaw_integrator_unit: Z-gyro rate integrator with bias calibration
// Sums calibration samples into a bias, then integrates bias-corrected,
// deadbanded rate times elapsed milliseconds into a saturating yaw count.
// ----------------------------------------------------------------------------
//
// Channel   Dir   Handshake     Payload
// sample    in    valid/ready   func, now_ms, gyro_raw
// result    out   valid/ready   yaw_acc, status (one per sample request)
// cfg       in    valid/ready   index, data (0 deadband_scaled, 1 min_interval_ms)
//
// Throughput is one request per clock while results are taken. Every request
// passes an input register (s1), a control/rate stage (s2), a multiply stage
// (s3) and the result register. The pace is set
// by the state loops: calibration sum, bias and last time close in the s1->s2
// step, the yaw accumulator closes in the saturating add into the result
// register. Reset (arst_n low) clears all state, empties the pipe and sets
// min_interval_ms to 4. A stalled result only holds the stages that are
// full; empty stages keep taking requests. cfg.ready is always high.
// ----------------------------------------------------------------------------
module gyro_yaw_integrator_unit #(
	parameter int CAL_SAMPLES = gyi_pkg::CAL_SAMPLES_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	gyi_sample_if.sink     sample,
	gyi_result_if.source   result,
	gyi_cfg_if.sink        cfg
);
	import gyi_pkg::*;

	// Count width follows the sample count; sums of that many raw samples
	// and raw*CAL_SAMPLES both fit in SUM_W signed bits.
	localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
	localparam int SUM_W  = RAW_W + CNT_W;
	localparam int RATE_W = SUM_W + 1;
	localparam int CMP_W  = (RATE_W > DEADBAND_W) ? RATE_W : DEADBAND_W;
	localparam int PROD_W = RATE_W + TIME_W + 1;

	localparam logic signed [SUM_W-1:0] CAL_N     = SUM_W'(CAL_SAMPLES);
	localparam logic [CNT_W-1:0]        CNT_LAST  = CNT_W'(CAL_SAMPLES - 1);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [DEADBAND_W-1:0] deadband_q;
	logic [INTERVAL_W-1:0] min_interval_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q     <= '0;
			min_interval_q <= MIN_INTERVAL_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DEADBAND:     deadband_q     <= cfg.data[DEADBAND_W-1:0];
				REG_MIN_INTERVAL: min_interval_q <= cfg.data[INTERVAL_W-1:0];
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline flow control: each stage advances when it is empty or the
	// stage behind it advances.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic rdy_out, rdy_s3, rdy_s2, rdy_s1;

	assign rdy_out      = !out_valid_q || result.ready;
	assign rdy_s3       = !v_s3 || rdy_out;
	assign rdy_s2       = !v_s2 || rdy_s3;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign sample.ready = rdy_s1;

	logic adv_s1, adv_s2, adv_s3;
	assign adv_s1 = v_s1 && rdy_s2;  // s1 request is processed into s2
	assign adv_s2 = v_s2 && rdy_s3;
	assign adv_s3 = v_s3 && rdy_out; // s3 request lands in the result register

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1        <= sample.valid;
			if (rdy_s2)  v_s2        <= v_s1;
			if (rdy_s3)  v_s3        <= v_s2;
			if (rdy_out) out_valid_q <= v_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register
	// ------------------------------------------------------------------
	logic  func_s1;
	time_t now_s1;
	raw_t  raw_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && sample.valid) begin
			func_s1 <= sample.func;
			now_s1  <= sample.now_ms;
			raw_s1  <= sample.gyro_raw;
		end
	end

	// ------------------------------------------------------------------
	// Calibration / timing state and the s1 -> s2 step
	// ------------------------------------------------------------------
	logic signed [SUM_W-1:0] cal_sum_q, bias_sum_q;
	logic [CNT_W-1:0]        cal_count_q;
	time_t                   last_time_q;

	logic signed [SUM_W-1:0]  cal_sum_n, bias_sum_n, raw_ext, scaled;
	logic [CNT_W-1:0]         cal_count_n;
	time_t                    last_time_n, diff;
	logic signed [RATE_W-1:0] rate_raw, rate_n;
	logic [RATE_W-1:0]        rate_mag;
	logic                     in_deadband;
	status_t                  status_n;

	assign raw_ext     = {{CNT_W{raw_s1[RAW_W-1]}}, raw_s1};
	assign scaled      = raw_ext * CAL_N;
	assign rate_raw    = {scaled[SUM_W-1], scaled} - {bias_sum_q[SUM_W-1], bias_sum_q};
	assign rate_mag    = rate_raw[RATE_W-1] ? RATE_W'(-rate_raw) : RATE_W'(rate_raw);
	assign in_deadband = CMP_W'(rate_mag) < CMP_W'(deadband_q);
	assign diff        = now_s1 - last_time_q;

	always_comb begin
		cal_sum_n   = cal_sum_q;
		bias_sum_n  = bias_sum_q;
		cal_count_n = cal_count_q;
		last_time_n = last_time_q;
		rate_n      = '0;
		status_n    = ST_CAL;
		if (!func_s1) begin
			cal_sum_n = cal_sum_q + raw_ext;
			if (cal_count_q == CNT_LAST) begin
				bias_sum_n  = cal_sum_n;
				cal_sum_n   = '0;
				cal_count_n = '0;
				status_n    = ST_CAL_DONE;
			end else begin
				cal_count_n = cal_count_q + CNT_W'(1);
				status_n    = ST_CAL;
			end
		end else if (last_time_q == '0) begin
			last_time_n = now_s1;
			status_n    = ST_FIRST;
		end else if (diff < TIME_W'(min_interval_q)) begin
			status_n = ST_SKIP;
		end else begin
			last_time_n = now_s1;
			rate_n      = in_deadband ? '0 : rate_raw;
			status_n    = ST_INTEG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_sum_q   <= '0;
			bias_sum_q  <= '0;
			cal_count_q <= '0;
			last_time_q <= '0;
		end else if (adv_s1) begin
			cal_sum_q   <= cal_sum_n;
			bias_sum_q  <= bias_sum_n;
			cal_count_q <= cal_count_n;
			last_time_q <= last_time_n;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: rate and elapsed time; rate is zero unless integrating
	// ------------------------------------------------------------------
	logic signed [RATE_W-1:0] rate_s2;
	time_t                    diff_s2;
	status_t                  status_s2;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rate_s2   <= rate_n;
			diff_s2   <= diff;
			status_s2 <= status_n;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: yaw increment = rate * elapsed ms
	// ------------------------------------------------------------------
	logic signed [PROD_W-1:0] delta_n, delta_s3;
	status_t                  status_s3;

	assign delta_n = rate_s2 * $signed({1'b0, diff_s2});

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			delta_s3  <= delta_n;
			status_s3 <= status_s2;
		end
	end

	// ------------------------------------------------------------------
	// Result register: saturating accumulate; it is also the yaw state
	// ------------------------------------------------------------------
	yaw_t                   yaw_total_q, yaw_next;
	status_t                status_q;
	logic signed [YAW_W:0]  yaw_sum;

	assign yaw_sum = {yaw_total_q[YAW_W-1], yaw_total_q}
		+ {{(YAW_W + 1 - PROD_W){delta_s3[PROD_W-1]}}, delta_s3};

	always_comb begin
		case (yaw_sum[YAW_W:YAW_W-1])
			2'b01:   yaw_next = {1'b0, {(YAW_W-1){1'b1}}};  // clamp at max
			2'b10:   yaw_next = {1'b1, {(YAW_W-1){1'b0}}};  // clamp at min
			default: yaw_next = yaw_sum[YAW_W-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_total_q <= '0;
		end else if (adv_s3) begin
			yaw_total_q <= yaw_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			status_q <= status_s3;
		end
	end

	assign result.valid   = out_valid_q;
	assign result.yaw_acc = yaw_total_q;
	assign result.status  = status_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_yaw_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s3 |=> $stable(yaw_total_q))
		else $error("yaw accumulator moved without a request landing");

	a_bias_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv_s1 && !func_s1 && cal_count_q == CNT_LAST) |=> $stable(bias_sum_q))
		else $error("bias changed outside calibration completion");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal_count_q <= CNT_LAST)
		else $error("calibration count beyond sample count");

	a_rate_only_integ: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && status_s2 != ST_INTEG |-> rate_s2 == '0)
		else $error("nonzero rate carried by a non-integrating request");

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the gyro yaw integrator unit
// Drives calibration and update requests over the sample channel, keeps a
// cycle-free model of the yaw, bias and timing state, and compares every
// result request field by field under varied idling, stalls and settings.
// ----------------------------------------------------------------------------
import gyi_pkg::*;

typedef struct {
	yaw_t    yaw_acc;
	status_t status;
} yaw_result_t;

// Tracks the integrator state per accepted request and checks results in order.
class yaw_scoreboard;
	int                    cal_n;
	longint                yaw_total;
	logic signed [24:0]    bias_sum;
	logic signed [24:0]    cal_sum;
	int unsigned           cal_count;
	time_t                 last_time;
	logic [DEADBAND_W-1:0] deadband;
	logic [INTERVAL_W-1:0] min_interval;
	yaw_result_t           expected_q[$];
	int                    mismatches;

	function new(int n);
		cal_n        = n;
		yaw_total    = 0;
		bias_sum     = '0;
		cal_sum      = '0;
		cal_count    = 0;
		last_time    = '0;
		deadband     = '0;
		min_interval = MIN_INTERVAL_RST;
		mismatches   = 0;
	endfunction

	function void write_register(cfg_idx_t idx, cfg_data_t value);
		case (idx)
			REG_DEADBAND:     deadband = value[DEADBAND_W-1:0];
			REG_MIN_INTERVAL: min_interval = value[INTERVAL_W-1:0];
			default: ;
		endcase
	endfunction

	function void note_sample(logic func, time_t now, raw_t raw);
		status_t     st;
		time_t       diff;
		longint      rate;
		longint      mag;
		longint      delta;
		longint      top_v;
		longint      bot_v;
		yaw_result_t res;
		top_v = 64'sh7FFF_FFFF_FFFF_FFFF;
		bot_v = -top_v - 1;
		if (!func) begin
			cal_sum = cal_sum + raw;
			cal_count++;
			if (cal_count >= cal_n) begin
				bias_sum  = cal_sum;
				cal_sum   = '0;
				cal_count = 0;
				st = ST_CAL_DONE;
			end else begin
				st = ST_CAL;
			end
		end else if (last_time == '0) begin
			last_time = now;
			st = ST_FIRST;
		end else begin
			diff = now - last_time;
			if (diff < min_interval) begin
				st = ST_SKIP;
			end else begin
				rate = longint'(raw) * longint'(cal_n) - longint'(bias_sum);
				mag  = (rate < 0) ? -rate : rate;
				last_time = now;
				if (mag < longint'(deadband)) rate = 0;
				delta = rate * longint'(diff);
				if (delta > 0 && yaw_total > top_v - delta) yaw_total = top_v;
				else if (delta < 0 && yaw_total < bot_v - delta) yaw_total = bot_v;
				else yaw_total = yaw_total + delta;
				st = ST_INTEG;
			end
		end
		res.yaw_acc = yaw_total;
		res.status  = st;
		expected_q.push_back(res);
	endfunction

	function void check_result(yaw_t yaw, status_t st);
		yaw_result_t want;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: yaw_acc=%0d status=%0d", yaw, st);
			return;
		end
		want = expected_q.pop_front();
		if (yaw !== want.yaw_acc || st !== want.status) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: yaw_acc exp %0d got %0d, status exp %0d got %0d",
					want.yaw_acc, yaw, want.status, st);
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb;

	localparam int CAL_N        = CAL_SAMPLES_DEF;
	localparam int LIMIT_CYCLES = 200000;
	localparam int HOLD_CYCLES  = 80;
	localparam int SETTLE       = 6;

	// Indexes beyond the register list; writes to them must change nothing.
	localparam cfg_idx_t REG_SPARE_2 = 2'd2;
	localparam cfg_idx_t REG_SPARE_3 = 2'd3;

	localparam raw_t RAW_MAX = 16'sh7FFF;
	localparam raw_t RAW_MIN = 16'sh8000;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic clk;
	logic arst_n;

	gyi_sample_if sample_ch ();
	gyi_result_if result_ch ();
	gyi_cfg_if    cfg_ch ();

	yaw_scoreboard sb;

	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          hold_token     = 0;
	int          hold_seen      = 0;
	int          hold_left      = 0;
	int unsigned cycles         = 0;

	gyro_yaw_integrator_unit #(
		.CAL_SAMPLES(CAL_N)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// 12 ns clock.
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: stall at random, or hold ready low for a long stretch when a
	// hold is requested, so the pipe fills up and backs up into the sender.
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: handshakes are sampled at the falling edge, where every signal
	// is settled; a request seen there completes at the next rising edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				sb.write_register(cfg_ch.index, cfg_ch.data);
			if (sample_ch.valid && sample_ch.ready)
				sb.note_sample(sample_ch.func, sample_ch.now_ms, sample_ch.gyro_raw);
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.yaw_acc, result_ch.status);
		end
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offer one sample request, idling first at the current rate, and hold it
	// until it is taken. Valid stays high into the next request.
	task automatic send_sample(input logic func, input time_t now, input raw_t raw);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid    <= 1'b1;
		sample_ch.func     <= func;
		sample_ch.now_ms   <= now;
		sample_ch.gyro_raw <= raw;
		do begin
			@(negedge clk);
			taken = sample_ch.ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Drop valid and wait until every expected result is back.
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t value);
		bit taken;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do begin
			@(negedge clk);
			taken = cfg_ch.ready;
			@(posedge clk);
		end while (!taken);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Write both registers; put junk above the interval field to check masking.
	task automatic configure(input logic [DEADBAND_W-1:0] band,
			input logic [INTERVAL_W-1:0] interval);
		write_reg(REG_DEADBAND, band);
		write_reg(REG_MIN_INTERVAL, {16'($urandom), interval});
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			IDLE_SEND: begin send_idle_pct = 56; recv_stall_pct = 0;  end
			IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 56; end
			default:   begin send_idle_pct = 10; recv_stall_pct = 10; end
		endcase
	endtask

	function automatic raw_t clip_raw(input longint v);
		if (v > 32767) return RAW_MAX;
		if (v < -32768) return RAW_MIN;
		return raw_t'(v);
	endfunction

	// Pick a rate sample: extremes, noise, values near the bias and values
	// right at the deadband edges around the bias.
	function automatic raw_t pick_raw();
		int unsigned k;
		longint      centre;
		longint      band;
		k      = $urandom_range(9);
		centre = longint'(sb.bias_sum) / CAL_N;
		band   = longint'(sb.deadband) / CAL_N;
		case (k)
			0:       return RAW_MAX;
			1:       return RAW_MIN;
			2, 3:    return raw_t'($urandom);
			4:       return clip_raw(centre + longint'($urandom_range(6)) - 3);
			5:       return clip_raw(centre + band + longint'($urandom_range(4)) - 2);
			6:       return clip_raw(centre - band + longint'($urandom_range(4)) - 2);
			default: return clip_raw(longint'($urandom_range(400)) - 200);
		endcase
	endfunction

	// One random request: mostly updates whose stamps walk forward from the
	// last integrated time, around the minimum interval; some calibration
	// samples, stamp zero, wrap-around and fully random stamps.
	task automatic send_random();
		int unsigned pick;
		logic        func;
		time_t       now;
		func = ($urandom_range(99) >= 10);
		pick = $urandom_range(19);
		if (pick == 0) now = '0;
		else if (pick <= 2) now = $urandom;
		else if (pick == 3) now = sb.last_time;
		else if (pick == 4) now = sb.last_time + sb.min_interval - 1;
		else if (pick == 5) now = sb.last_time + sb.min_interval;
		else if (pick == 6) now = sb.last_time - time_t'($urandom_range(1, 1000));
		else now = sb.last_time + time_t'($urandom_range(3 * sb.min_interval + 8));
		send_sample(func, now, pick_raw());
	endtask

	task automatic run_random(input idle_mode_t mode, input logic [DEADBAND_W-1:0] band,
			input logic [INTERVAL_W-1:0] interval, input int count, input bit hold);
		set_idling(mode);
		configure(band, interval);
		if (hold) hold_token++;
		repeat (count) send_random();
		drain();
	endtask

	// Feed calibration samples near one extreme until the bias latches.
	task automatic run_calibration(input raw_t base, input int jitter_sign);
		int n;
		int j;
		n = CAL_N - int'(sb.cal_count);
		repeat (n) begin
			j = $urandom_range(2);
			send_sample(1'b0, $urandom, clip_raw(longint'(base) + jitter_sign * j));
		end
	endtask

	// Integrate one rate over near-full-wrap intervals to drive the yaw
	// into saturation.
	task automatic push_yaw(input raw_t raw, input int count);
		repeat (count) send_sample(1'b1, sb.last_time + 32'hFFFF_FFF0, raw);
	endtask

	initial begin
		sb = new(CAL_N);
		arst_n             = 1'b0;
		sample_ch.valid    = 1'b0;
		sample_ch.func     = 1'b0;
		sample_ch.now_ms   = '0;
		sample_ch.gyro_raw = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = REG_DEADBAND;
		cfg_ch.data        = '0;
		result_ch.ready    = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part at reset settings: deadband 0, interval 4.
		set_idling(IDLE_NONE);
		send_sample(1'b1, 32'd0, 16'sd0);           // stamp zero keeps timing unstarted
		send_sample(1'b1, 32'd0, RAW_MAX);
		send_sample(1'b1, 32'd100, RAW_MAX);        // first update records the time
		send_sample(1'b1, 32'd103, RAW_MIN);        // too soon
		send_sample(1'b1, 32'd104, RAW_MIN);        // exactly the interval
		send_sample(1'b1, 32'hFFFF_FFF0, RAW_MAX);  // huge step
		send_sample(1'b1, 32'd5, raw_t'(-1));       // stamp wraps
		send_sample(1'b1, 32'd0, RAW_MAX);          // integrates and lands on zero
		send_sample(1'b1, 32'd50, 16'sd1);          // timing restarts
		send_sample(1'b0, 32'd0, RAW_MAX);
		send_sample(1'b0, 32'hFFFF_FFFF, RAW_MIN);
		send_sample(1'b0, 32'd7, 16'sd0);
		send_sample(1'b0, 32'd9, raw_t'(-1));
		send_sample(1'b1, 32'd54, 16'sd0);
		send_sample(1'b1, 32'd54, 16'sh5A5A);       // zero elapsed, skipped
		send_sample(1'b1, 32'hA5A5_A5A5, 16'sh5A5A);
		drain();

		// Widest deadband, zero interval; spare indexes must be ignored.
		configure(24'hFFFFFF, 8'd0);
		write_reg(REG_SPARE_2, 24'h000001);
		write_reg(REG_SPARE_3, 24'hFFFFFF);
		send_sample(1'b1, 32'hA5A5_A5A5, RAW_MAX);  // zero elapsed now integrates
		send_sample(1'b1, 32'hA5A5_A5A6, RAW_MIN);  // inside the deadband
		send_sample(1'b1, 32'hA5A5_A5A8, RAW_MAX);
		drain();

		// Deadband edge: a magnitude equal to the band integrates.
		configure(24'd1000, 8'd1);
		send_sample(1'b1, 32'hA5A5_A5A9, 16'sd2);
		send_sample(1'b1, 32'hA5A5_A5AB, raw_t'(-1));
		send_sample(1'b1, 32'hA5A5_A5AE, raw_t'(-2));
		drain();

		// Latch a bias near the negative extreme with the receiver stalling and one
		// long hold, so the sample channel backs up.
		set_idling(IDLE_RECV);
		hold_token++;
		run_calibration(RAW_MIN, 1);
		drain();

		// Drive the yaw to the positive limit and beyond.
		set_idling(IDLE_BOTH);
		configure(24'd0, 8'd0);
		push_yaw(RAW_MAX, 72);
		drain();

		// Random updates around the latched bias and the deadband edges.
		run_random(IDLE_SEND, 24'($urandom_range(20000)), 8'($urandom_range(16)), 40, 1'b0);

		drain();
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/gyi_pkg.sv
rtl/gyi_if.sv
rtl/gyro_yaw_integrator_unit.sv
bench/tb.sv
